@@ rtl/jct_pkg.sv @@
// Shared types and constants for the jump chain threader.
// Used by jct_engine, jump_chain_threader_core and the testbench; depends on nothing else.
package jct_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int OP_W            = 2;
	localparam int TGT_W           = 7;
	localparam int IDX_OUT_W       = 6;
	localparam int CHG_W           = 7;
	localparam int HOPS_W          = 8;
	localparam logic [HOPS_W-1:0] HOPS_RESET = 8'd100;

	typedef enum logic [OP_W-1:0] {
		OP_OTHER = 2'd0,
		OP_NOP   = 2'd1,
		OP_JUMP  = 2'd2,
		OP_CJUMP = 2'd3
	} op_kind_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ENT_RD,
		ST_ENT_EV,
		ST_WALK_CHK,
		ST_WALK_EV,
		ST_NOP_RD,
		ST_NOP_EV,
		ST_FIN,
		ST_EMIT
	} seq_state_t;

	// one stored program entry
	typedef struct packed {
		op_kind_t           op;
		logic [TGT_W-1:0]   tgt;
	} entry_t;

	// input item as seen by the engine
	typedef struct packed {
		logic               valid;
		op_kind_t           op;
		logic [TGT_W-1:0]   tgt;
		logic               last;
	} load_t;

	// result offered by the engine to the output register
	typedef struct packed {
		logic                 valid;
		logic [IDX_OUT_W-1:0] index;
		logic [TGT_W-1:0]     target;
		logic                 changed;
		logic [CHG_W-1:0]     total;
		logic                 last;
	} result_t;

endpackage

@@ rtl/jct_engine.sv @@
// Program store and chain-walk sequencer of the jump chain threader.
// Depends on jct_pkg; instantiated by jump_chain_threader_core.
module jct_engine #(
	parameter int MAX_ENTRIES = jct_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  jct_pkg::load_t              ld,
	output logic                        ld_ready,
	input  logic [jct_pkg::HOPS_W-1:0]  max_hops,
	output jct_pkg::result_t            res,
	input  logic                        res_ready
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > jct_pkg::TGT_W) ? CNT_W : jct_pkg::TGT_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	jct_pkg::seq_state_t state_q, state_d;

	jct_pkg::entry_t store_q [MAX_ENTRIES];
	jct_pkg::entry_t rdata_q;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic             wr_en;
	jct_pkg::entry_t  wr_data;

	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] n_q, n_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] cur_q, cur_d;
	logic [CNT_W-1:0] scan_q, scan_d;
	logic [CNT_W-1:0] base_q, base_d;
	logic             post_q, post_d;
	logic [jct_pkg::HOPS_W-1:0] hops_q, hops_d;
	jct_pkg::op_kind_t kind_q, kind_d;
	logic [jct_pkg::TGT_W-1:0] tgt_q, tgt_d;
	logic [jct_pkg::CHG_W-1:0] chg_q, chg_d;
	logic [MAX_ENTRIES-1:0]    vis_q, vis_d;
	logic [jct_pkg::TGT_W-1:0] rtgt_q, rtgt_d;
	logic                      rchg_q, rchg_d;

	logic [CMP_W-1:0] nt;
	logic [CMP_W-1:0] n_ext, cur_ext, tgt_ext, rd_tgt_ext;
	logic [IDX_W-1:0] cur_idx;
	logic             is_last;

	assign n_ext      = CMP_W'(n_q);
	assign cur_ext    = CMP_W'(cur_q);
	assign tgt_ext    = CMP_W'(tgt_q);
	assign rd_tgt_ext = CMP_W'(rdata_q.tgt);
	assign cur_idx    = cur_q[IDX_W-1:0];
	assign is_last    = (idx_q + 1'b1) == n_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		n_d      = n_q;
		idx_d    = idx_q;
		cur_d    = cur_q;
		scan_d   = scan_q;
		base_d   = base_q;
		post_d   = post_q;
		hops_d   = hops_q;
		kind_d   = kind_q;
		tgt_d    = tgt_q;
		chg_d    = chg_q;
		vis_d    = vis_q;
		rtgt_d   = rtgt_q;
		rchg_d   = rchg_q;
		rd_addr  = idx_q[IDX_W-1:0];
		wr_en    = 1'b0;
		wr_addr  = cnt_q[IDX_W-1:0];
		wr_data  = '{op: ld.op, tgt: ld.tgt};
		ld_ready = 1'b0;
		nt       = cur_ext;
		res.valid = 1'b0;
		unique case (state_q)
			jct_pkg::ST_LOAD: begin
				ld_ready = 1'b1;
				if (ld.valid) begin
					// entries past the store depth are dropped
					if (cnt_q < MAX_CNT) begin
						wr_en = 1'b1;
						cnt_d = cnt_q + 1'b1;
					end
					if (ld.last) begin
						n_d     = (cnt_q < MAX_CNT) ? cnt_q + 1'b1 : cnt_q;
						cnt_d   = '0;
						idx_d   = '0;
						chg_d   = '0;
						state_d = jct_pkg::ST_ENT_RD;
					end
				end
			end
			jct_pkg::ST_ENT_RD: begin
				state_d = jct_pkg::ST_ENT_EV;
			end
			jct_pkg::ST_ENT_EV: begin
				kind_d = rdata_q.op;
				tgt_d  = rdata_q.tgt;
				if ((rdata_q.op == jct_pkg::OP_JUMP || rdata_q.op == jct_pkg::OP_CJUMP)
						&& rd_tgt_ext < n_ext) begin
					cur_d   = CNT_W'(rdata_q.tgt);
					hops_d  = '0;
					vis_d   = '0;
					state_d = jct_pkg::ST_WALK_CHK;
				end else begin
					rtgt_d  = rdata_q.tgt;
					rchg_d  = 1'b0;
					state_d = jct_pkg::ST_EMIT;
				end
			end
			jct_pkg::ST_WALK_CHK: begin
				rd_addr = cur_idx;
				if (cur_q >= n_q || hops_q >= max_hops || vis_q[cur_idx]) begin
					// chain ends: skip trailing no-ops from here
					base_d  = cur_q;
					scan_d  = cur_q;
					post_d  = 1'b1;
					state_d = jct_pkg::ST_NOP_RD;
				end else begin
					vis_d[cur_idx] = 1'b1;
					state_d        = jct_pkg::ST_WALK_EV;
				end
			end
			jct_pkg::ST_WALK_EV: begin
				if (rdata_q.op == jct_pkg::OP_NOP) begin
					base_d  = cur_q;
					scan_d  = cur_q + 1'b1;
					post_d  = 1'b0;
					state_d = jct_pkg::ST_NOP_RD;
				end else if (rdata_q.op == jct_pkg::OP_JUMP && rd_tgt_ext <= n_ext) begin
					cur_d   = CNT_W'(rdata_q.tgt);
					hops_d  = hops_q + 1'b1;
					state_d = jct_pkg::ST_WALK_CHK;
				end else begin
					state_d = jct_pkg::ST_FIN;
				end
			end
			jct_pkg::ST_NOP_RD: begin
				rd_addr = scan_q[IDX_W-1:0];
				if (scan_q >= n_q) begin
					// only no-ops onward: stay where the scan began
					cur_d   = base_q;
					state_d = post_q ? jct_pkg::ST_FIN : jct_pkg::ST_WALK_CHK;
				end else begin
					state_d = jct_pkg::ST_NOP_EV;
				end
			end
			jct_pkg::ST_NOP_EV: begin
				if (rdata_q.op == jct_pkg::OP_NOP) begin
					scan_d  = scan_q + 1'b1;
					state_d = jct_pkg::ST_NOP_RD;
				end else begin
					cur_d   = scan_q;
					state_d = post_q ? jct_pkg::ST_FIN : jct_pkg::ST_WALK_CHK;
				end
			end
			jct_pkg::ST_FIN: begin
				// never move a conditional jump backward
				if (kind_q == jct_pkg::OP_CJUMP && cur_ext < tgt_ext)
					nt = tgt_ext;
				rtgt_d = jct_pkg::TGT_W'(nt);
				if (nt != tgt_ext) begin
					wr_en   = 1'b1;
					wr_addr = idx_q[IDX_W-1:0];
					wr_data = '{op: kind_q, tgt: jct_pkg::TGT_W'(nt)};
					chg_d   = chg_q + 1'b1;
					rchg_d  = 1'b1;
				end else begin
					rchg_d  = 1'b0;
				end
				state_d = jct_pkg::ST_EMIT;
			end
			jct_pkg::ST_EMIT: begin
				res.valid = 1'b1;
				if (res_ready) begin
					if (is_last) begin
						state_d = jct_pkg::ST_LOAD;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = jct_pkg::ST_ENT_RD;
					end
				end
			end
			default: begin
				state_d = jct_pkg::ST_LOAD;
			end
		endcase
	end

	assign res.index   = jct_pkg::IDX_OUT_W'(idx_q);
	assign res.target  = rtgt_q;
	assign res.changed = rchg_q;
	assign res.total   = chg_q;
	assign res.last    = is_last;

	always_ff @(posedge clk) begin
		if (wr_en)
			store_q[wr_addr] <= wr_data;
		rdata_q <= store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jct_pkg::ST_LOAD;
			cnt_q   <= '0;
			chg_q   <= '0;
			vis_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			chg_q   <= chg_d;
			vis_q   <= vis_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q    <= n_d;
		idx_q  <= idx_d;
		cur_q  <= cur_d;
		scan_q <= scan_d;
		base_q <= base_d;
		post_q <= post_d;
		hops_q <= hops_d;
		kind_q <= kind_d;
		tgt_q  <= tgt_d;
		rtgt_q <= rtgt_d;
		rchg_q <= rchg_d;
	end

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jct_pkg::ST_EMIT |-> idx_q < n_q)
		else $error("result index beyond program length");

	a_hop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jct_pkg::ST_WALK_EV |-> hops_q < max_hops)
		else $error("chain walked past hop limit");

	a_fin_target: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jct_pkg::ST_FIN |-> cur_q <= n_q)
		else $error("chain ended beyond exit");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("entry count overflow");

	a_load_to_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jct_pkg::ST_LOAD && ld.valid && ld.last |=>
			state_q == jct_pkg::ST_ENT_RD && cnt_q == '0)
		else $error("last item did not start a run");

endmodule

@@ rtl/jump_chain_threader_core.sv @@
// Top level of the jump chain threader: configuration register and output register.
// Depends on jct_pkg and jct_engine.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | in        | in_valid / in_ready  | op_kind, target_index, last_entry
//  out     | out       | out_valid / out_ready| entry_index, final_target, retargeted,
//          |           |                      | total_changes, last_result
//  cfg     | in        | cfg_wr_en (no wait)  | cfg_wr_data -> max_chain_hops
//
// Loading takes one item per cycle until the item with last_entry.
// The run then reads, evaluates and emits each entry in turn. A jump with an in-range target
// also walks its chain and skips no-ops before the chain ends, every store read going through
// the one read port of the program store.
// in_ready is low for the whole run; no clearing pass follows reset.
// A stalled out_ready holds the output register and freezes the sequencer at its next result.
module jump_chain_threader_core #(
	parameter int MAX_ENTRIES = jct_pkg::MAX_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [jct_pkg::OP_W-1:0]       op_kind,
	input  logic [jct_pkg::TGT_W-1:0]      target_index,
	input  logic                           last_entry,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [jct_pkg::IDX_OUT_W-1:0]  entry_index,
	output logic [jct_pkg::TGT_W-1:0]      final_target,
	output logic                           retargeted,
	output logic [jct_pkg::CHG_W-1:0]      total_changes,
	output logic                           last_result,
	input  logic                           cfg_wr_en,
	input  logic [jct_pkg::HOPS_W-1:0]     cfg_wr_data
);

	logic [jct_pkg::HOPS_W-1:0] max_hops_q;
	jct_pkg::load_t   ld;
	jct_pkg::result_t res;
	logic             ld_ready;
	logic             res_ready;
	logic             out_valid_q;

	assign ld.valid = in_valid;
	assign ld.op    = jct_pkg::op_kind_t'(op_kind);
	assign ld.tgt   = target_index;
	assign ld.last  = last_entry;
	assign in_ready = ld_ready;

	// take a new result when the register is empty or being drained
	assign res_ready = !out_valid_q || out_ready;

	jct_engine #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld),
		.ld_ready  (ld_ready),
		.max_hops  (max_hops_q),
		.res       (res),
		.res_ready (res_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hops_q  <= jct_pkg::HOPS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				max_hops_q <= cfg_wr_data;
			if (res.valid && res_ready)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			entry_index   <= res.index;
			final_target  <= res.target;
			retargeted    <= res.changed;
			total_changes <= res.total;
			last_result   <= res.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ tb/jump_chain_threader_core_tb.sv @@
// Self-checking testbench for jump_chain_threader_core: loads programs, threads them in a
// local model and compares every result item in order. Depends on jct_pkg and the RTL top.
module jump_chain_threader_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import jct_pkg::*;

	localparam int MAX_PROG    = MAX_ENTRIES_DEF;
	localparam int DIR_ROWS    = 25;
	localparam int SETTLE      = 4;
	localparam int END_WAIT    = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NO_WRITE    = -1;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] index;
		logic [TGT_W-1:0]     target;
		logic                 changed;
		logic [CHG_W-1:0]     total;
		logic                 last;
	} thread_res_t;

	typedef struct {
		op_kind_t         op;
		logic [TGT_W-1:0] tgt;
		bit               last;
		int               hops;     // hop limit written before this row, NO_WRITE for none
		bit               typed;
		logic [TGT_W-1:0] want_tgt;
		bit               want_chg;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      op_kind = '0;
	logic [TGT_W-1:0]     target_index = '0;
	logic                 last_entry = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [IDX_OUT_W-1:0] entry_index;
	logic [TGT_W-1:0]     final_target;
	logic                 retargeted;
	logic [CHG_W-1:0]     total_changes;
	logic                 last_result;
	logic                 cfg_wr_en = 1'b0;
	logic [HOPS_W-1:0]    cfg_wr_data = '0;

	// program image as the block should hold it
	op_kind_t         prog_op [MAX_PROG];
	logic [TGT_W-1:0] prog_tgt [MAX_PROG];
	int               row_of [MAX_PROG];
	bit               seen [MAX_PROG];
	int               prog_len = 0;
	int               hop_limit = HOPS_RESET;
	int               taken = 0;

	thread_res_t due_results [$];
	int          mismatches = 0;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          calm_left = 0;
	bit          no_gaps = 0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// two-hop chain, extremes of target, exit target
		'{OP_OTHER, 7'd127, 0, NO_WRITE, 1, 7'd127, 0},
		'{OP_JUMP,  7'd3,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_CJUMP, 7'd0,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_JUMP,  7'd5,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_JUMP,  7'd6,   0, NO_WRITE, 1, 7'd6,   0},
		'{OP_OTHER, 7'd0,   1, NO_WRITE, 0, 7'd0,   0},
		// jump loop, conditional jump that would move backward
		'{OP_JUMP,  7'd1,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_JUMP,  7'd0,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_CJUMP, 7'd3,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_NOP,   7'd85,  0, NO_WRITE, 0, 7'd0,   0},
		'{OP_JUMP,  7'd0,   1, NO_WRITE, 0, 7'd0,   0},
		// chain ends on an out-of-range jump, no-ops to the end
		'{OP_JUMP,  7'd1,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_JUMP,  7'd100, 0, NO_WRITE, 1, 7'd100, 0},
		'{OP_CJUMP, 7'd4,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_NOP,   7'd42,  0, NO_WRITE, 0, 7'd0,   0},
		'{OP_NOP,   7'd127, 1, NO_WRITE, 0, 7'd0,   0},
		// zero hop limit: only no-ops are skipped
		'{OP_JUMP,  7'd1,   0, 0,        1, 7'd2,   1},
		'{OP_NOP,   7'd0,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_JUMP,  7'd3,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_OTHER, 7'd9,   1, NO_WRITE, 0, 7'd0,   0},
		// single-entry program
		'{OP_CJUMP, 7'd0,   1, NO_WRITE, 0, 7'd0,   0},
		// hop limit of one truncates the chain
		'{OP_JUMP,  7'd1,   0, 1,        0, 7'd0,   0},
		'{OP_JUMP,  7'd2,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_JUMP,  7'd3,   0, NO_WRITE, 0, 7'd0,   0},
		'{OP_OTHER, 7'd0,   1, NO_WRITE, 0, 7'd0,   0}
	};

	jump_chain_threader_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op_kind       (op_kind),
		.target_index  (target_index),
		.last_entry    (last_entry),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.entry_index   (entry_index),
		.final_target  (final_target),
		.retargeted    (retargeted),
		.total_changes (total_changes),
		.last_result   (last_result),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int skip_noops(int start);
		int idx;
		idx = start;
		while (idx < prog_len && prog_op[idx] == OP_NOP)
			idx++;
		return (idx < prog_len) ? idx : start;
	endfunction

	function automatic int follow_chain(int start);
		int cur;
		int hops;
		cur = start;
		hops = 0;
		while (cur < prog_len && hops < hop_limit) begin
			if (seen[cur])
				break;
			seen[cur] = 1;
			if (prog_op[cur] == OP_NOP) begin
				cur = skip_noops(cur);
			end else if (prog_op[cur] == OP_JUMP && prog_tgt[cur] <= prog_len) begin
				cur = prog_tgt[cur];
				hops++;
			end else begin
				break;
			end
		end
		return cur;
	endfunction

	// thread every jump in index order and queue one result per entry
	function automatic void thread_program();
		thread_res_t r;
		int t;
		int nt;
		int chg;
		int row;
		bit moved;
		chg = 0;
		for (int i = 0; i < prog_len; i++) begin
			t = prog_tgt[i];
			moved = 0;
			if ((prog_op[i] == OP_JUMP || prog_op[i] == OP_CJUMP) && t < prog_len) begin
				foreach (seen[j])
					seen[j] = 0;
				nt = skip_noops(follow_chain(t));
				if (prog_op[i] == OP_CJUMP && nt < t)
					nt = t;
				if (nt != t) begin
					prog_tgt[i] = TGT_W'(nt);
					chg++;
					moved = 1;
				end
			end
			r.index = IDX_OUT_W'(i);
			r.target = prog_tgt[i];
			r.changed = moved;
			r.total = CHG_W'(chg);
			r.last = (i + 1 == prog_len);
			row = row_of[i];
			if (row >= 0 && dir_rows[row].typed) begin
				r.target = dir_rows[row].want_tgt;
				r.changed = dir_rows[row].want_chg;
			end
			due_results.push_back(r);
		end
		prog_len = 0;
	endfunction

	function automatic void take_item(op_kind_t op, logic [TGT_W-1:0] tgt, logic last);
		// drop entries once the store is full
		if (prog_len < MAX_PROG) begin
			prog_op[prog_len] = op;
			prog_tgt[prog_len] = tgt;
			row_of[prog_len] = (taken < DIR_ROWS) ? taken : -1;
			prog_len++;
		end
		taken++;
		if (last)
			thread_program();
	endfunction

	function automatic void flag(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			take_item(op_kind_t'(op_kind), target_index, last_entry);
	end

	always @(posedge clk) begin
		thread_res_t w;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				flag($sformatf("unexpected result: index %0d target %0d", entry_index,
					final_target));
			end else begin
				w = due_results.pop_front();
				if ({entry_index, final_target, retargeted, total_changes, last_result} !== w)
					flag($sformatf({"mismatch: expected idx %0d tgt %0d chg %0d tot %0d last %0d,",
						" got idx %0d tgt %0d chg %0d tot %0d last %0d"},
						w.index, w.target, w.changed, w.total, w.last, entry_index,
						final_target, retargeted, total_changes, last_result));
			end
		end
	end

	// receiver: random stalls with occasional calm stretches
	always @(posedge clk) begin
		if (calm_left > 0)
			calm_left--;
		else if ($urandom_range(99) == 0)
			calm_left = 40;
		out_ready <= (calm_left > 0) || ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(op_kind_t op, logic [TGT_W-1:0] tgt, logic last);
		int gap;
		gap = (!no_gaps && $urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op_kind <= op;
		target_index <= tgt;
		last_entry <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// hold off until every queued result is back and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_hop_limit(int value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= HOPS_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		hop_limit = value;
	endtask

	task automatic send_program(int len);
		op_kind_t op;
		int pick;
		bit noise;
		logic [TGT_W-1:0] tgt;
		no_gaps = ($urandom_range(3) == 0);
		noise = ($urandom_range(5) == 0);
		for (int k = 0; k < len; k++) begin
			pick = $urandom_range(9);
			if (noise)
				op = op_kind_t'($urandom_range(3));
			else
				op = (pick < 2) ? OP_OTHER : (pick < 4) ? OP_NOP : (pick < 8) ? OP_JUMP : OP_CJUMP;
			// mostly in range or the exit; now and then anywhere
			if (noise || $urandom_range(9) == 0)
				tgt = TGT_W'($urandom_range(127));
			else
				tgt = TGT_W'($urandom_range(len));
			send_item(op, tgt, k == len - 1);
		end
	endtask

	task automatic random_phase(int snd, int stl, int hops, int count);
		int sent;
		int len;
		set_hop_limit(hops);
		send_idle_pct = snd;
		stall_pct = stl;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
			send_program(len);
			sent += len;
			if ($urandom_range(4) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 8;
		stall_pct = 66;
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].hops != NO_WRITE)
				set_hop_limit(dir_rows[r].hops);
			send_item(dir_rows[r].op, dir_rows[r].tgt, dir_rows[r].last);
		end

		random_phase(8, 66, 255, 15);
		random_phase(66, 8, $urandom_range(2, 8), 15);
		// overfill the store with no idling on either side
		random_phase(0, 0, $urandom_range(255), 0);
		send_program(MAX_PROG + 2);

		drain();
		repeat (END_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
